// File: rtl/fixed_head_disk_io_controller_assert.svh
// ----------------------------------------------------------------------------
// Fixed-head disk IO controller assertion macros
// Shorthand for the clocked, reset-gated checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIXED_HEAD_DISK_IO_CONTROLLER_ASSERT_SVH
`define FIXED_HEAD_DISK_IO_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define FHD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fhd: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define FHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fhd: next-cycle check failed");

`endif

// File: rtl/fhd_pkg.sv
// ----------------------------------------------------------------------------
// fhd_pkg
// Types, codes and constants shared by the fixed-head disk controller files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fhd_pkg;

  // Default geometry
  localparam int SECTOR_WORDS_DEF = 256;
  localparam int DISK_COUNT_DEF   = 8;

  // Field widths
  localparam int SECT_ADDR_W  = 13;
  localparam int DISK_SHIFT   = 10;  // sectors per disk = 2**DISK_SHIFT
  localparam int WORD_W       = 16;
  localparam int DISK_WORD_W  = 21;
  localparam int STATUS_W     = 5;
  localparam int POS_W        = 3;
  localparam int MAP_IDX_W    = 6;

  // Status bits
  localparam logic [STATUS_W-1:0] ST_WLS = 5'o20;
  localparam logic [STATUS_W-1:0] ST_NSD = 5'o04;
  localparam logic [STATUS_W-1:0] ST_ERR = 5'o01;

  typedef enum logic {
    CMD_IO   = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    IO_NIO = 3'd0,
    IO_DIA = 3'd1,
    IO_DOA = 3'd2,
    IO_DIB = 3'd3,
    IO_DOB = 3'd4,
    IO_DIC = 3'd5,
    IO_DOC = 3'd6,
    IO_SKP = 3'd7
  } io_code_e;

  typedef enum logic [1:0] {
    PULSE_NONE  = 2'd0,
    PULSE_READ  = 2'd1,
    PULSE_CLEAR = 2'd2,
    PULSE_WRITE = 2'd3
  } pulse_e;

  typedef enum logic [1:0] {
    CFG_PLATTERS   = 2'd0,
    CFG_WRITE_LOCK = 2'd1,
    CFG_ADDR_MASK  = 2'd2
  } cfg_index_e;

  // Sector interleave map, indexed by the low six sector address bits
  localparam logic [POS_W-1:0] INTERLEAVE [64] = '{
    3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd7,
    3'd1, 3'd3, 3'd5, 3'd7, 3'd2, 3'd4, 3'd6, 3'd0,
    3'd2, 3'd4, 3'd6, 3'd0, 3'd3, 3'd5, 3'd7, 3'd1,
    3'd3, 3'd5, 3'd7, 3'd1, 3'd4, 3'd6, 3'd0, 3'd2,
    3'd4, 3'd6, 3'd0, 3'd2, 3'd5, 3'd7, 3'd1, 3'd3,
    3'd5, 3'd7, 3'd1, 3'd3, 3'd6, 3'd0, 3'd2, 3'd4,
    3'd6, 3'd0, 3'd2, 3'd4, 3'd7, 3'd1, 3'd3, 3'd5,
    3'd7, 3'd1, 3'd3, 3'd5, 3'd0, 3'd2, 3'd4, 3'd6
  };

  typedef struct packed {
    logic [3:0]        platters;
    logic [7:0]        write_lock;
    logic [WORD_W-1:0] addr_mask;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    io_code_e          io_code;
    pulse_e            pulse;
    logic [WORD_W-1:0] ac_value;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0]      read_data;
    logic                   busy_res;
    logic                   done_res;
    logic [STATUS_W-1:0]    status;
    logic                   xfer_valid;
    logic                   xfer_write;
    logic [DISK_WORD_W-1:0] xfer_disk_word;
    logic [WORD_W-1:0]      xfer_mem_addr;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/fixed_head_disk_io_controller.sv
// ----------------------------------------------------------------------------
// fixed_head_disk_io_controller
// Register side of a head-per-track disk controller: IO instructions and
// sector ticks in, one status and transfer descriptor result per item out.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  input    | in_valid_i / in_stall_o  | cmd, io_code, pulse, ac_value
//  output   | out_valid_o / out_stall_i| read_data .. xfer_mem_addr
//  config   | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One item per cycle unless the output stalls (input register, result register).
//  The state update runs in a single pass between those two registers.
//  Reset clears all flags, addresses and the platter position at once.
//  in_stall_o rises only while a held result is stalled and the input
//  register is full; config writes are taken in every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_head_disk_io_controller_assert.svh"

module fixed_head_disk_io_controller #(
  parameter int SECTOR_WORDS = fhd_pkg::SECTOR_WORDS_DEF,
  parameter int DISK_COUNT   = fhd_pkg::DISK_COUNT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input transactions
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic                             cmd_i,
  input  wire logic [2:0]                       io_code_i,
  input  wire logic [1:0]                       pulse_i,
  input  wire logic [fhd_pkg::WORD_W-1:0]       ac_value_i,
  // Result transactions
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [fhd_pkg::WORD_W-1:0]       read_data_o,
  output      logic                             busy_res_o,
  output      logic                             done_res_o,
  output      logic [fhd_pkg::STATUS_W-1:0]     status_o,
  output      logic                             xfer_valid_o,
  output      logic                             xfer_write_o,
  output      logic [fhd_pkg::DISK_WORD_W-1:0]  xfer_disk_word_o,
  output      logic [fhd_pkg::WORD_W-1:0]       xfer_mem_addr_o,
  // Configuration writes
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [1:0]                       cfg_index_i,
  input  wire logic [fhd_pkg::WORD_W-1:0]       cfg_data_i
);

  fhd_pkg::cfg_t  cfg;
  fhd_pkg::item_t item_q;
  fhd_pkg::res_t  res_comb;
  fhd_pkg::res_t  res_q;
  logic           in_valid_q, in_valid_d;
  logic           out_valid_q, out_valid_d;
  logic           advance;
  logic           in_accept;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  fhd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Move the held item on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  // Handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.cmd      <= fhd_pkg::cmd_e'(cmd_i);
      item_q.io_code  <= fhd_pkg::io_code_e'(io_code_i);
      item_q.pulse    <= fhd_pkg::pulse_e'(pulse_i);
      item_q.ac_value <= ac_value_i;
    end
  end

  // Controller state and update
  fhd_exec #(
    .SECTOR_WORDS (SECTOR_WORDS),
    .DISK_COUNT   (DISK_COUNT)
  ) u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_comb)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = res_q.read_data;
  assign busy_res_o       = res_q.busy_res;
  assign done_res_o       = res_q.done_res;
  assign status_o         = res_q.status;
  assign xfer_valid_o     = res_q.xfer_valid;
  assign xfer_write_o     = res_q.xfer_write;
  assign xfer_disk_word_o = res_q.xfer_disk_word;
  assign xfer_mem_addr_o  = res_q.xfer_mem_addr;

  // Checks
  `FHD_ASSERT_IMPL(a_stall_from_backpressure, in_stall_o, out_valid_o && out_stall_i)
  `FHD_ASSERT_IMPL(a_idle_descriptor_zero, out_valid_o && !xfer_valid_o, !xfer_write_o && xfer_disk_word_o == '0 && xfer_mem_addr_o == '0)
  `FHD_ASSERT_IMPL(a_xfer_sets_done, out_valid_o && xfer_valid_o, done_res_o && !busy_res_o && status_o == '0)
  `FHD_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_o)

endmodule

`default_nettype wire

// File: rtl/fhd_cfg_regs.sv
// ----------------------------------------------------------------------------
// fhd_cfg_regs
// Configuration register file: platters, write lock switches, address mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhd_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [1:0]                  wr_index_i,
  input  wire logic [fhd_pkg::WORD_W-1:0]  wr_data_i,
  output fhd_pkg::cfg_t                    cfg_o
);

  fhd_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes leave all registers alone
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (fhd_pkg::cfg_index_e'(wr_index_i))
        fhd_pkg::CFG_PLATTERS:   cfg_d.platters   = wr_data_i[3:0];
        fhd_pkg::CFG_WRITE_LOCK: cfg_d.write_lock = wr_data_i[7:0];
        fhd_pkg::CFG_ADDR_MASK:  cfg_d.addr_mask  = wr_data_i;
        default: ;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.platters   <= 4'd1;
      cfg_q.write_lock <= 8'd0;
      cfg_q.addr_mask  <= 16'h7FFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/fhd_exec.sv
// ----------------------------------------------------------------------------
// fhd_exec
// Controller state and its single-pass update for one instruction or tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhd_exec #(
  parameter int SECTOR_WORDS = fhd_pkg::SECTOR_WORDS_DEF,
  parameter int DISK_COUNT   = fhd_pkg::DISK_COUNT_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire fhd_pkg::item_t item_i,
  input  wire fhd_pkg::cfg_t  cfg_i,
  output fhd_pkg::res_t       res_o
);

  localparam int SA_W   = fhd_pkg::SECT_ADDR_W;
  localparam int WW     = fhd_pkg::WORD_W;
  localparam int SW     = fhd_pkg::STATUS_W;
  localparam int PW     = fhd_pkg::POS_W;
  localparam int PROD_W = SA_W + $clog2(SECTOR_WORDS + 1);
  localparam int LIM_W  = SA_W + 1;

  localparam logic [WW-1:0]     READ_STEP  = WW'(SECTOR_WORDS);
  localparam logic [WW-1:0]     WRITE_STEP = WW'(SECTOR_WORDS + 3);
  localparam logic [3:0]        NP_MAX     = 4'(DISK_COUNT);
  localparam logic [PROD_W-1:0] SW_MUL     = PROD_W'(SECTOR_WORDS);

  logic [SW-1:0]   status_q, status_d;
  logic [SA_W-1:0] sa_q, sa_d;
  logic [WW-1:0]   mem_q, mem_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            pw_q, pw_d;
  logic [PW-1:0]   wait_q, wait_d;
  logic [PW-1:0]   pos_q, pos_d;

  logic [3:0]        np;
  logic [LIM_W-1:0]  sa_limit;
  logic              lock_hit;
  logic              no_disk;
  logic [PW-1:0]     map_sector;
  logic [PROD_W-1:0] disk_prod;

  // Start checks look at the sector address after this instruction's load
  assign np         = (cfg_i.platters > NP_MAX) ? NP_MAX : cfg_i.platters;
  assign sa_limit   = {np, {(LIM_W - 4){1'b0}}};
  assign lock_hit   = cfg_i.write_lock[sa_d[SA_W-1:fhd_pkg::DISK_SHIFT]];
  assign no_disk    = ({1'b0, sa_d} >= sa_limit);
  assign map_sector = fhd_pkg::INTERLEAVE[sa_d[fhd_pkg::MAP_IDX_W-1:0]];
  assign disk_prod  = PROD_W'(sa_q) * SW_MUL;

  // Next state and result for the current item
  always_comb begin
    status_d = status_q;
    sa_d     = sa_q;
    mem_d    = mem_q;
    busy_d   = busy_q;
    done_d   = done_q;
    pw_d     = pw_q;
    wait_d   = wait_q;
    pos_d    = pos_q;
    res_o    = '0;

    if (item_i.cmd == fhd_pkg::CMD_IO) begin
      // Data transfer part of the instruction
      case (item_i.io_code)
        fhd_pkg::IO_DIA: res_o.read_data = {{(WW - SW){1'b0}}, status_q};
        fhd_pkg::IO_DOA: sa_d = item_i.ac_value[SA_W-1:0];
        fhd_pkg::IO_DIB: res_o.read_data = mem_q & cfg_i.addr_mask;
        fhd_pkg::IO_DOB: mem_d = item_i.ac_value & cfg_i.addr_mask;
        fhd_pkg::IO_DIC: res_o.read_data = READ_STEP;
        default: ;
      endcase

      // Any pulse drops the flags and cancels the pending transfer
      if (item_i.pulse != fhd_pkg::PULSE_NONE) begin
        busy_d   = 1'b0;
        done_d   = 1'b0;
        status_d = '0;
      end

      // Start: fail at once, or arm the rotational wait
      if (item_i.pulse == fhd_pkg::PULSE_READ || item_i.pulse == fhd_pkg::PULSE_WRITE) begin
        if (item_i.pulse == fhd_pkg::PULSE_WRITE && lock_hit) begin
          done_d   = 1'b1;
          status_d = fhd_pkg::ST_ERR | fhd_pkg::ST_WLS;
        end else if (no_disk) begin
          done_d   = 1'b1;
          status_d = fhd_pkg::ST_ERR | fhd_pkg::ST_NSD;
        end else begin
          pw_d   = (item_i.pulse == fhd_pkg::PULSE_WRITE);
          busy_d = 1'b1;
          wait_d = map_sector - pos_q;
        end
      end
    end else begin
      // Sector tick: if busy, count down the wait and complete on the last one; then advance the position
      if (busy_q) begin
        if (wait_q <= PW'(1)) begin
          busy_d               = 1'b0;
          done_d               = 1'b1;
          res_o.xfer_valid     = 1'b1;
          res_o.xfer_write     = pw_q;
          res_o.xfer_disk_word = disk_prod[fhd_pkg::DISK_WORD_W-1:0];
          res_o.xfer_mem_addr  = mem_q & cfg_i.addr_mask;
          mem_d    = (mem_q + (pw_q ? WRITE_STEP : READ_STEP)) & cfg_i.addr_mask;
          status_d = '0;
          wait_d   = '0;
        end else begin
          wait_d = wait_q - PW'(1);
        end
      end
      pos_d = pos_q + PW'(1);
    end

    res_o.busy_res = busy_d;
    res_o.done_res = done_d;
    res_o.status   = status_d;
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      sa_q     <= '0;
      mem_q    <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      pw_q     <= 1'b0;
      wait_q   <= '0;
      pos_q    <= '0;
    end else if (step_i) begin
      status_q <= status_d;
      sa_q     <= sa_d;
      mem_q    <= mem_d;
      busy_q   <= busy_d;
      done_q   <= done_d;
      pw_q     <= pw_d;
      wait_q   <= wait_d;
      pos_q    <= pos_d;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_fixed_head_disk_io_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_head_disk_io_controller
// Self-checking bench for the fixed-head disk controller register side. A
// behavioral model of the controller predicts one result per input
// transaction. A short directed run is followed by random phases, each under
// its own register setting. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_fixed_head_disk_io_controller;

  localparam int unsigned SECTOR_SIZE      = fhd_pkg::SECTOR_WORDS_DEF;
  localparam int unsigned DISKS            = fhd_pkg::DISK_COUNT_DEF;
  localparam int unsigned SECTORS_PER_DISK = 1 << fhd_pkg::DISK_SHIFT;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned PHASES           = 10;
  localparam int unsigned PHASE_ITEMS      = 107;
  localparam int          WORD_W           = fhd_pkg::WORD_W;
  localparam int          STATUS_W         = fhd_pkg::STATUS_W;
  localparam int          DISK_WORD_W      = fhd_pkg::DISK_WORD_W;

  // Rotational slot of each sector, indexed by the low six address bits
  localparam logic [2:0] ROT_SLOT [64] = '{
    3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd7,
    3'd1, 3'd3, 3'd5, 3'd7, 3'd2, 3'd4, 3'd6, 3'd0,
    3'd2, 3'd4, 3'd6, 3'd0, 3'd3, 3'd5, 3'd7, 3'd1,
    3'd3, 3'd5, 3'd7, 3'd1, 3'd4, 3'd6, 3'd0, 3'd2,
    3'd4, 3'd6, 3'd0, 3'd2, 3'd5, 3'd7, 3'd1, 3'd3,
    3'd5, 3'd7, 3'd1, 3'd3, 3'd6, 3'd0, 3'd2, 3'd4,
    3'd6, 3'd0, 3'd2, 3'd4, 3'd7, 3'd1, 3'd3, 3'd5,
    3'd7, 3'd1, 3'd3, 3'd5, 3'd0, 3'd2, 3'd4, 3'd6
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   cmd_i = 1'b0;
  logic [2:0]             io_code_i = '0;
  logic [1:0]             pulse_i = '0;
  logic [WORD_W-1:0]      ac_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [WORD_W-1:0]      read_data_o;
  logic                   busy_res_o;
  logic                   done_res_o;
  logic [STATUS_W-1:0]    status_o;
  logic                   xfer_valid_o;
  logic                   xfer_write_o;
  logic [DISK_WORD_W-1:0] xfer_disk_word_o;
  logic [WORD_W-1:0]      xfer_mem_addr_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i = '0;
  logic [WORD_W-1:0]      cfg_data_i = '0;

  fixed_head_disk_io_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .io_code_i        (io_code_i),
    .pulse_i          (pulse_i),
    .ac_value_i       (ac_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o),
    .busy_res_o       (busy_res_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .xfer_valid_o     (xfer_valid_o),
    .xfer_write_o     (xfer_write_o),
    .xfer_disk_word_o (xfer_disk_word_o),
    .xfer_mem_addr_o  (xfer_mem_addr_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Controller model state and its register copy
  fhd_pkg::cfg_t       cfg_shadow = '{platters: 4'd1, write_lock: 8'h00, addr_mask: 16'h7FFF};
  logic [STATUS_W-1:0] m_status = '0;
  logic [12:0]         m_sector = '0;
  logic [WORD_W-1:0]   m_mem = '0;
  logic                m_busy = 1'b0;
  logic                m_done = 1'b0;
  logic                m_pend_write = 1'b0;
  logic [2:0]          m_wait = '0;
  logic [2:0]          m_pos = '0;

  fhd_pkg::item_t pending_instr_q [$];
  fhd_pkg::res_t  due_results_q [$];
  fhd_pkg::item_t cur_item;
  bit             in_taken = 1'b0;
  bit             idle_on = 1'b1;
  int unsigned    in_gap_left = 0;
  int unsigned    stall_left = 0;
  int unsigned    items_pushed = 0;
  int unsigned    fail_count = 0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Length of one idle stretch: mostly short, now and then long
  function automatic int unsigned draw_idle_len();
    return ($urandom_range(99) < 88) ? $urandom_range(3, 1) : $urandom_range(30, 8);
  endfunction

  // Apply one instruction or sector tick to the model, return the result
  task automatic predict_disk_result(input fhd_pkg::item_t it, output fhd_pkg::res_t r);
    logic [2:0]  disk;
    int unsigned np;
    int unsigned dw;
    r = '0;
    if (it.cmd == fhd_pkg::CMD_IO) begin
      case (it.io_code)
        fhd_pkg::IO_DIA: r.read_data = WORD_W'(m_status);
        fhd_pkg::IO_DOA: m_sector = it.ac_value[12:0];
        fhd_pkg::IO_DIB: r.read_data = m_mem & cfg_shadow.addr_mask;
        fhd_pkg::IO_DOB: m_mem = it.ac_value & cfg_shadow.addr_mask;
        fhd_pkg::IO_DIC: r.read_data = SECTOR_SIZE[WORD_W-1:0];
        default: ;
      endcase
      // Any pulse cancels whatever is pending
      if (it.pulse != fhd_pkg::PULSE_NONE) begin
        m_busy = 1'b0;
        m_done = 1'b0;
        m_status = '0;
      end
      if (it.pulse == fhd_pkg::PULSE_READ || it.pulse == fhd_pkg::PULSE_WRITE) begin
        disk = m_sector[12:10];
        np = (cfg_shadow.platters > DISKS) ? DISKS : cfg_shadow.platters;
        if (it.pulse == fhd_pkg::PULSE_WRITE && cfg_shadow.write_lock[disk]) begin
          m_done = 1'b1;
          m_status = fhd_pkg::ST_ERR | fhd_pkg::ST_WLS;
        end else if (m_sector >= np * SECTORS_PER_DISK) begin
          m_done = 1'b1;
          m_status = fhd_pkg::ST_ERR | fhd_pkg::ST_NSD;
        end else begin
          m_pend_write = (it.pulse == fhd_pkg::PULSE_WRITE);
          m_busy = 1'b1;
          m_wait = ROT_SLOT[m_sector[5:0]] - m_pos;
        end
      end
    end else begin
      // Sector tick: finish or count down the wait, then rotate
      if (m_busy) begin
        if (m_wait <= 3'd1) begin
          dw = m_sector * SECTOR_SIZE;
          m_busy = 1'b0;
          m_done = 1'b1;
          r.xfer_valid = 1'b1;
          r.xfer_write = m_pend_write;
          r.xfer_disk_word = dw[DISK_WORD_W-1:0];
          r.xfer_mem_addr = m_mem & cfg_shadow.addr_mask;
          m_mem = (m_mem + SECTOR_SIZE + (m_pend_write ? 3 : 0)) & cfg_shadow.addr_mask;
          m_status = '0;
          m_wait = '0;
        end else begin
          m_wait = m_wait - 3'd1;
        end
      end
      m_pos = m_pos + 3'd1;
    end
    r.busy_res = m_busy;
    r.done_res = m_done;
    r.status = m_status;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Input driver: hold a stalled transaction, else insert a gap or present the next one
  always @(negedge clk_i) begin : instr_driver
    logic next_valid;
    next_valid = in_valid_i && !in_taken;
    if (!next_valid) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
      end else if (pending_instr_q.size() != 0) begin
        cur_item = pending_instr_q.pop_front();
        next_valid = 1'b1;
        in_gap_left = (idle_on && $urandom_range(99) < 35) ? draw_idle_len() : 0;
        cmd_i <= cur_item.cmd;
        io_code_i <= cur_item.io_code;
        pulse_i <= cur_item.pulse;
        ac_value_i <= cur_item.ac_value;
      end
    end
    in_valid_i <= next_valid;
    in_taken = 1'b0;
  end

  // Predict on every accepted input transaction
  always @(posedge clk_i) begin : instr_accept
    fhd_pkg::res_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_disk_result(cur_item, r);
      due_results_q.push_back(r);
      in_taken = 1'b1;
    end
  end

  // Result stall generator
  always @(negedge clk_i) begin
    if (stall_left == 0 && idle_on && $urandom_range(99) < 20) stall_left = draw_idle_len();
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor: compare against the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    fhd_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results_q.size() == 0) begin
        $error("result transaction with no prediction waiting");
        fail_count++;
      end else begin
        want = due_results_q.pop_front();
        check_field("read_data", want.read_data, read_data_o);
        check_field("busy_res", want.busy_res, busy_res_o);
        check_field("done_res", want.done_res, done_res_o);
        check_field("status", want.status, status_o);
        check_field("xfer_valid", want.xfer_valid, xfer_valid_o);
        check_field("xfer_write", want.xfer_write, xfer_write_o);
        check_field("xfer_disk_word", want.xfer_disk_word, xfer_disk_word_o);
        check_field("xfer_mem_addr", want.xfer_mem_addr, xfer_mem_addr_o);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_item(input fhd_pkg::cmd_e c, input fhd_pkg::io_code_e code,
                           input fhd_pkg::pulse_e p, input logic [WORD_W-1:0] ac);
    fhd_pkg::item_t it;
    it.cmd = c;
    it.io_code = code;
    it.pulse = p;
    it.ac_value = ac;
    pending_instr_q.push_back(it);
    items_pushed++;
  endtask

  // Sector tick with random don't-care fields
  task automatic push_tick();
    push_item(fhd_pkg::CMD_TICK, fhd_pkg::io_code_e'($urandom_range(7)),
              fhd_pkg::pulse_e'($urandom_range(3)), 16'($urandom));
  endtask

  task automatic write_config_reg(input fhd_pkg::cfg_index_e idx,
                                  input logic [WORD_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      fhd_pkg::CFG_PLATTERS:   cfg_shadow.platters = data[3:0];
      fhd_pkg::CFG_WRITE_LOCK: cfg_shadow.write_lock = data[7:0];
      fhd_pkg::CFG_ADDR_MASK:  cfg_shadow.addr_mask = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [3:0] plat, input logic [7:0] lock,
                               input logic [WORD_W-1:0] mask);
    write_config_reg(fhd_pkg::CFG_PLATTERS, {12'($urandom), plat});
    write_config_reg(fhd_pkg::CFG_WRITE_LOCK, {8'($urandom), lock});
    write_config_reg(fhd_pkg::CFG_ADDR_MASK, mask);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every transaction has been answered, then let the pipeline settle
  task automatic drain_and_settle();
    while (pending_instr_q.size() != 0 || in_valid_i || due_results_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One sector transfer: load addresses, start, tick a random number of times, read back
  task automatic gen_sector_transfer();
    int unsigned       np;
    int unsigned       nticks;
    logic [2:0]        disk;
    fhd_pkg::io_code_e code;
    fhd_pkg::pulse_e   p;
    np = (cfg_shadow.platters > DISKS) ? DISKS : cfg_shadow.platters;
    if (np != 0 && $urandom_range(9) < 8) disk = 3'($urandom_range(np - 1));
    else disk = 3'($urandom_range(7));
    p = fhd_pkg::pulse_e'(($urandom_range(1) != 0) ? fhd_pkg::PULSE_WRITE
                                                    : fhd_pkg::PULSE_READ);
    if ($urandom_range(1))
      push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DOB, fhd_pkg::PULSE_NONE, 16'($urandom));
    if ($urandom_range(3) == 0) begin
      push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DOA, fhd_pkg::PULSE_NONE,
                {3'($urandom), disk, 10'($urandom)});
      code = fhd_pkg::io_code_e'($urandom_range(7));
      if (code == fhd_pkg::IO_DOA) code = fhd_pkg::IO_NIO;
      push_item(fhd_pkg::CMD_IO, code, p, 16'($urandom));
    end else begin
      push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DOA, p, {3'($urandom), disk, 10'($urandom)});
    end
    nticks = ($urandom_range(9) != 0) ? $urandom_range(9, 1) : $urandom_range(3);
    repeat (nticks) begin
      if ($urandom_range(19) == 0)
        push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_NIO, fhd_pkg::PULSE_CLEAR, 16'($urandom));
      if ($urandom_range(5) == 0)
        push_item(fhd_pkg::CMD_IO,
                  fhd_pkg::io_code_e'(($urandom_range(1) != 0) ? fhd_pkg::IO_DIA
                                                                : fhd_pkg::IO_DIB),
                  fhd_pkg::PULSE_NONE, 16'($urandom));
      push_tick();
    end
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DIA, fhd_pkg::PULSE_NONE, 16'($urandom));
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DIB, fhd_pkg::PULSE_NONE, 16'($urandom));
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned target;
    logic [3:0]  plat;
    logic [7:0]  lock;
    logic [15:0] mask;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: two disks, disk 1 locked, full address mask
    apply_setting(4'd2, 8'h02, 16'hFFFF);
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DIC, fhd_pkg::PULSE_NONE, 16'h0000);
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DOB, fhd_pkg::PULSE_NONE, 16'hFFFF);
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DIB, fhd_pkg::PULSE_NONE, 16'h0000);
    // Address beyond the installed disks
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DOA, fhd_pkg::PULSE_READ, 16'hFFFF);
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DIA, fhd_pkg::PULSE_NONE, 16'h0000);
    // Write to a locked disk, then read status and clear in one instruction
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DOA, fhd_pkg::PULSE_WRITE, 16'h0400);
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DIA, fhd_pkg::PULSE_CLEAR, 16'h0000);
    // Read from the locked disk is fine; memory address wraps past the top
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DOA, fhd_pkg::PULSE_READ, 16'h0400);
    repeat (8) push_item(fhd_pkg::CMD_TICK, fhd_pkg::IO_SKP, fhd_pkg::PULSE_WRITE, 16'hFFFF);
    // Write transfer, with the codes that move no data during the wait
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DOA, fhd_pkg::PULSE_WRITE, 16'h03FF);
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DOC, fhd_pkg::PULSE_NONE, 16'hFFFF);
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_SKP, fhd_pkg::PULSE_NONE, 16'hFFFF);
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_NIO, fhd_pkg::PULSE_NONE, 16'hFFFF);
    repeat (8) push_item(fhd_pkg::CMD_TICK, fhd_pkg::IO_NIO, fhd_pkg::PULSE_NONE, 16'h0000);
    push_item(fhd_pkg::CMD_IO, fhd_pkg::IO_DIB, fhd_pkg::PULSE_NONE, 16'h0000);
    drain_and_settle();

    // Random phases, extremes of the registers first
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin plat = 4'd0;  lock = 8'h00; mask = 16'h0000; end
        1: begin plat = 4'd15; lock = 8'hFF; mask = 16'hFFFF; end
        2: begin plat = 4'd8;  lock = 8'h00; mask = 16'hFFFF; end
        3: begin plat = 4'd1;  lock = 8'h00; mask = 16'h7FFF; end
        4: begin plat = 4'd9;  lock = 8'($urandom); mask = 16'($urandom); end
        default: begin
          plat = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
          lock = 8'($urandom) & 8'($urandom);
          mask = 16'($urandom);
        end
      endcase
      idle_on = (ph % 4 != 2);
      apply_setting(plat, lock, mask);
      target = items_pushed + PHASE_ITEMS;
      while (items_pushed < target) begin
        if ($urandom_range(4) != 0) begin
          gen_sector_transfer();
        end else begin
          repeat ($urandom_range(3, 1))
            push_item(fhd_pkg::cmd_e'($urandom_range(1)),
                      fhd_pkg::io_code_e'($urandom_range(7)),
                      fhd_pkg::pulse_e'($urandom_range(3)), 16'($urandom));
        end
      end
      drain_and_settle();
    end

    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
